### design/dgb_pkg.sv
// ----------------------------------------------------------------------------
// dgb_pkg
// shared types, constants and tables for the delay gradient backoff unit
// ----------------------------------------------------------------------------
package dgb_pkg;

	localparam int WINDOW = 8;
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int RTT_W = 20;
	localparam int GRAD_W = 21;
	localparam int SUM_W = 25;
	localparam int OUT_GRAD_W = 25;
	localparam int CFG_W = 16;
	localparam int IDX_W = 2;
	localparam int IN_W = 96;
	localparam int OUT_W = 64;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_ROUND = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [1:0] REG_BETA = 2'd0;
	localparam logic [1:0] REG_FACTOR = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;
	localparam logic [1:0] REG_PERIOD = 2'd3;

	localparam logic [1:0] Q_UNKNOWN = 2'd0;
	localparam logic [1:0] Q_NONFULL = 2'd1;
	localparam logic [1:0] Q_FULL = 2'd2;

	localparam logic [31:0] EXP_STEP = 32'(32'hFFFF_FFFF / 1000000);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GRAD,
		ST_PICK,
		ST_INIT,
		ST_EXP,
		ST_DECIDE,
		ST_THRESH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic sample;
		logic restart;
		logic grad;
		logic pick;
		logic exp_init;
		logic exp_step;
		logic decide;
		logic thresh;
		logic out_valid;
	} cmd_t;

	typedef struct packed {
		logic round_kind;
		logic nonempty;
		logic exp_done;
	} status_t;

	function automatic logic [16:0] exp_coef(input logic [4:0] k);
		logic [16:0] v;
		case (k)
			5'd1: v = 17'd65519;
			5'd2: v = 17'd65502;
			5'd3: v = 17'd65469;
			5'd4: v = 17'd65402;
			5'd5: v = 17'd65268;
			5'd6: v = 17'd65002;
			5'd7: v = 17'd64471;
			5'd8: v = 17'd63423;
			5'd9: v = 17'd61379;
			5'd10: v = 17'd57485;
			5'd11: v = 17'd50424;
			5'd12: v = 17'd38796;
			5'd13: v = 17'd22966;
			5'd14: v = 17'd8048;
			5'd15: v = 17'd988;
			5'd16: v = 17'd15;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

endpackage

### design/delay_gradient_backoff_unit.sv
// ----------------------------------------------------------------------------
// delay_gradient_backoff_unit
// delay-gradient backoff decision for a congestion controller
// ----------------------------------------------------------------------------
// s_axis carries one item per rtt sample, round end or restart, with the kind
// on s_axis_tuser. samples and restarts produce nothing; a round end
// produces one m_axis item with the chosen gradient, the backoff flag, the
// new threshold and the queue state.
// every item runs the gradient state; a round end with samples then runs pick,
// exp init, exponential, decide and threshold, and every round end ends in
// output. the exponential applies one table factor per cycle through a single
// 32x17 multiplier for up to sixteen steps, stopping early once no exponent
// bits are left or the argument is too large. one item is in work at a time;
// the result sits in an output register and the next item is taken while it
// waits, but a further round end waits until it is taken. reset zeroes all
// round history and configuration registers. the user must write configuration
// through cfg_we/cfg_index/cfg_data only while idle; the block does not check.
// ----------------------------------------------------------------------------
module delay_gradient_backoff_unit import dgb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// rtt_ms, segments_acked, cwnd, in_avoidance, random_word, pad
	input  logic [IN_W-1:0]     s_axis_tdata,
	// kind
	input  logic [1:0]          s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// gradient, back_off, new_threshold, queue_state, pad
	output logic [OUT_W-1:0]    m_axis_tdata,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	cmd_t cmd;
	status_t status;
	logic in_ready, fire, out_free, vld_q;
	logic [10:0] beta_q;
	logic [15:0] factor_q;
	logic [7:0] limit_q, period_q;
	logic signed [OUT_GRAD_W-1:0] gradient;
	logic back_off;
	logic [31:0] new_threshold;
	logic [1:0] queue_state;

	assign out_free = !vld_q || m_axis_tready;
	assign s_axis_tready = in_ready;
	assign fire = s_axis_tvalid && in_ready;
	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = {4'b0, queue_state, new_threshold, back_off, gradient};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			beta_q <= '0; factor_q <= '0; limit_q <= '0; period_q <= '0;
		end else begin
			if (cmd.out_valid) vld_q <= 1'b1;
			else if (m_axis_tready) vld_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BETA: beta_q <= cfg_data[10:0];
					REG_FACTOR: factor_q <= cfg_data;
					REG_LIMIT: limit_q <= cfg_data[7:0];
					REG_PERIOD: period_q <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	dgb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(fire), .out_free(out_free),
		.status(status), .in_ready(in_ready), .cmd(cmd)
	);

	dgb_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_kind(s_axis_tuser),
		.in_data(s_axis_tdata),
		.beta_scaled(beta_q), .gradient_factor(factor_q),
		.ineffective_limit(limit_q), .ineffective_period(period_q),
		.status(status), .gradient(gradient), .back_off(back_off),
		.new_threshold(new_threshold), .queue_state(queue_state)
	);

endmodule

### design/dgb_ctrl.sv
// ----------------------------------------------------------------------------
// dgb_ctrl
// sequencer for sample, restart and round-end items
// ----------------------------------------------------------------------------
module dgb_ctrl import dgb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  logic    out_free,
	input  status_t status,
	output logic    in_ready,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_GRAD;
			ST_GRAD: begin
				if (!status.round_kind) state_d = ST_IDLE;
				else if (!status.nonempty) state_d = ST_OUT;
				else state_d = ST_PICK;
			end
			ST_PICK: state_d = ST_INIT;
			ST_INIT: state_d = ST_EXP;
			ST_EXP: if (status.exp_done) state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_THRESH;
			ST_THRESH: state_d = ST_OUT;
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_fire;
			end
			ST_GRAD: begin
				cmd.sample = 1'b1;
				cmd.restart = 1'b1;
				cmd.grad = 1'b1;
			end
			ST_PICK: cmd.pick = 1'b1;
			ST_INIT: cmd.exp_init = 1'b1;
			ST_EXP: cmd.exp_step = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			ST_THRESH: cmd.thresh = 1'b1;
			ST_OUT: cmd.out_valid = out_free;
			default: ;
		endcase
	end

endmodule

### design/dgb_datapath.sv
// ----------------------------------------------------------------------------
// dgb_datapath
// round min/max, gradient ring, smoothing, exponential and backoff decision
// ----------------------------------------------------------------------------
module dgb_datapath import dgb_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	input  logic [1:0]                   in_kind,
	input  logic [IN_W-1:0]              in_data,
	input  logic [10:0]                  beta_scaled,
	input  logic [15:0]                  gradient_factor,
	input  logic [7:0]                   ineffective_limit,
	input  logic [7:0]                   ineffective_period,
	output status_t                      status,
	output logic signed [OUT_GRAD_W-1:0] gradient,
	output logic                         back_off,
	output logic [31:0]                  new_threshold,
	output logic [1:0]                   queue_state
);

	logic [1:0] kind_q;
	logic [RTT_W-1:0] rtt_q;
	logic [7:0] acked_q;
	logic [31:0] cwnd_q, rnd_q;
	logic avoid_q;

	logic [RTT_W-1:0] round_min_q, round_max_q, prior_min_q, prior_max_q;
	logic signed [GRAD_W-1:0] min_ring_q [WINDOW];
	logic signed [GRAD_W-1:0] max_ring_q [WINDOW];
	logic signed [SUM_W-1:0] min_sum_q, max_sum_q;
	logic [SLOT_W-1:0] slot_q;
	logic [8:0] bcount_q;
	logic [2:0] dack_q;
	logic [1:0] class_q;

	logic signed [GRAD_W-1:0] gmin_q, gmax_q;
	logic have_prior_q;
	logic signed [OUT_GRAD_W-1:0] grad_q;
	logic back_q;
	logic [31:0] thresh_q;
	logic [31:0] acc_q;
	logic [15:0] hi_q;
	logic [4:0] k_q;
	logic big_q;
	logic [42:0] tprod_q;

	logic signed [GRAD_W-1:0] gmin_c, gmax_c;
	logic signed [SUM_W-1:0] nmin_sum, nmax_sum;
	logic signed [SUM_W-1:0] tmin, tmax;
	logic signed [SUM_W-1:0] smin_c, smax_c;
	logic [40:0] gx;
	logic [48:0] mul_c;
	logic [8:0] binc;

	assign gmin_c = GRAD_W'($signed({1'b0, round_min_q})) - GRAD_W'($signed({1'b0, prior_min_q}));
	assign gmax_c = GRAD_W'($signed({1'b0, round_max_q})) - GRAD_W'($signed({1'b0, prior_max_q}));
	assign nmin_sum = min_sum_q + SUM_W'(gmin_c) - SUM_W'(min_ring_q[slot_q]);
	assign nmax_sum = max_sum_q + SUM_W'(gmax_c) - SUM_W'(max_ring_q[slot_q]);
	assign tmin = (min_sum_q < 0) ? min_sum_q + SUM_W'(WINDOW - 1) : min_sum_q;
	assign tmax = (max_sum_q < 0) ? max_sum_q + SUM_W'(WINDOW - 1) : max_sum_q;
	assign smin_c = tmin >>> SLOT_W;
	assign smax_c = tmax >>> SLOT_W;
	assign gx = 41'(grad_q[23:0]) * 41'(gradient_factor);
	assign mul_c = 49'(acc_q) * 49'(exp_coef(k_q));
	assign binc = (bcount_q < 9'd511) ? bcount_q + 9'd1 : bcount_q;

	assign status.round_kind = (kind_q == KIND_ROUND);
	assign status.nonempty = (round_min_q != '0) || (round_max_q != '0);
	assign status.exp_done = big_q || hi_q == '0 || k_q == 5'd17;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			rtt_q <= in_data[19:0];
			acked_q <= in_data[27:20];
			cwnd_q <= in_data[59:28];
			avoid_q <= in_data[60];
			rnd_q <= in_data[92:61];
		end
		if (cmd.grad) begin
			gmin_q <= gmin_c;
			gmax_q <= gmax_c;
			have_prior_q <= (prior_min_q != '0) || (prior_max_q != '0);
		end
		if (cmd.exp_init) begin
			big_q <= gx[40:24] != '0;
			hi_q <= gx[23:8];
			k_q <= 5'd1;
			acc_q <= 32'hFFFF_FFFF - 32'(gx[7:0]) * EXP_STEP;
		end else if (cmd.exp_step && !status.exp_done) begin
			if (hi_q[0]) acc_q <= mul_c[47:16];
			hi_q <= hi_q >> 1;
			k_q <= k_q + 5'd1;
		end
		if (cmd.decide) tprod_q <= 43'(cwnd_q) * 43'(beta_scaled);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_min_q <= '0; round_max_q <= '0;
			prior_min_q <= '0; prior_max_q <= '0;
			for (int i = 0; i < WINDOW; i++) begin
				min_ring_q[i] <= '0; max_ring_q[i] <= '0;
			end
			min_sum_q <= '0; max_sum_q <= '0; slot_q <= '0;
			bcount_q <= '0; dack_q <= '0; class_q <= Q_UNKNOWN;
			grad_q <= '0; back_q <= 1'b0; thresh_q <= '0;
			gradient <= '0; back_off <= 1'b0; new_threshold <= '0; queue_state <= Q_UNKNOWN;
		end else begin
			if (cmd.sample && kind_q == KIND_SAMPLE && rtt_q != '0) begin
				if (round_min_q == '0 || rtt_q < round_min_q) round_min_q <= rtt_q;
				if (acked_q == 8'd1 && dack_q != '0) begin
					dack_q <= dack_q - 3'd1;
				end else begin
					if (acked_q > 8'd1 && dack_q < 3'd5) dack_q <= dack_q + 3'd1;
					if (rtt_q > round_max_q) round_max_q <= rtt_q;
				end
			end
			if (cmd.restart && kind_q == KIND_RESTART) begin
				round_min_q <= '0; round_max_q <= '0;
				prior_min_q <= '0; prior_max_q <= '0;
				for (int i = 0; i < WINDOW; i++) begin
					min_ring_q[i] <= '0; max_ring_q[i] <= '0;
				end
				min_sum_q <= '0; max_sum_q <= '0; slot_q <= '0;
				bcount_q <= '0; dack_q <= '0; class_q <= Q_UNKNOWN;
			end
			if (cmd.grad && status.round_kind) begin
				grad_q <= '0;
				back_q <= 1'b0;
				thresh_q <= '0;
				if (status.nonempty) begin
					if ((prior_min_q != '0) || (prior_max_q != '0)) begin
						min_sum_q <= nmin_sum;
						max_sum_q <= nmax_sum;
						min_ring_q[slot_q] <= gmin_c;
						max_ring_q[slot_q] <= gmax_c;
						slot_q <= (32'(slot_q) + 1 >= WINDOW) ? '0 : slot_q + 1'b1;
					end
					prior_min_q <= round_min_q;
					prior_max_q <= round_max_q;
					round_min_q <= '0;
					round_max_q <= '0;
				end
			end
			if (cmd.pick && have_prior_q) begin
				if (avoid_q) grad_q <= (smin_c > 0) ? smin_c : smax_c;
				else if (gmin_q > 0) grad_q <= SUM_W'(gmin_q);
				else if (smin_c >= 0) grad_q <= smin_c;
				else grad_q <= (gmax_q > 0) ? SUM_W'(gmax_q) : smax_c;
				if (smin_c > 0 && smax_c <= 0) class_q <= Q_FULL;
				else if ((smin_c > 0 && smax_c > 0) || smax_c < 0) class_q <= Q_NONFULL;
				if (smin_c < 0 || smax_c < 0) bcount_q <= '0;
			end
			if (cmd.decide && grad_q > 0 && rnd_q > (big_q ? 32'd0 : acc_q)) begin
				if (ineffective_limit != '0 && binc > {1'b0, ineffective_limit}) begin
					bcount_q <= (binc >= {1'b0, ineffective_limit} + {1'b0, ineffective_period})
						? '0 : binc;
				end else begin
					bcount_q <= binc;
					back_q <= 1'b1;
				end
			end
			if (cmd.thresh && back_q) begin
				thresh_q <= (tprod_q[42:10] > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF :
					(tprod_q[42:10] < 33'd2) ? 32'd2 : tprod_q[41:10];
			end
			if (cmd.out_valid) begin
				gradient <= grad_q;
				back_off <= back_q;
				new_threshold <= thresh_q;
				queue_state <= class_q;
			end
		end
	end

endmodule

### design/dgb_checker.sv
// ----------------------------------------------------------------------------
// dgb_checker
// port-level checks for the delay gradient backoff unit
// ----------------------------------------------------------------------------
module dgb_checker import dgb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [IN_W-1:0]  s_axis_tdata,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output item changed under stall");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted two items back to back");

	a_thresh: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[25] |-> m_axis_tdata[57:26] == 32'd0)
		else $error("threshold without backoff");

	a_min2: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[25] |-> m_axis_tdata[57:27] != 31'd0)
		else $error("threshold below two");

	a_qs: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[59:58] != 2'd3)
		else $error("bad queue state");

endmodule

bind delay_gradient_backoff_unit dgb_checker u_dgb_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.s_axis_tdata(s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
